### rtl/assert_macros.svh
// Assertion macros, included by sm4_block_encrypt.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/sm4_pkg.sv
// Shared types, constants and the S-box for the SM4 block cipher core.
// No dependencies; imported by every module of the core.
package sm4_pkg;

  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);

  typedef enum logic {
    REQ_KEY = 1'b0,
    REQ_ENC = 1'b1
  } sm4_req_e;

  typedef struct packed {
    sm4_req_e    req_type;
    logic [4:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } sm4_out_t;

  // Round-key store write port.
  typedef struct packed {
    logic             en;
    logic [RND_W-1:0] addr;
    logic [31:0]      data;
  } sm4_key_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

endpackage

### rtl/sm4_key_ram.sv
// Round-key store: 32 words, one write port, one read port with registered data.
// Depends on sm4_pkg for the write-port struct and widths.
module sm4_key_ram
  import sm4_pkg::*;
(
  input  logic             clk_i,
  input  sm4_key_wr_t      wr_i,
  input  logic [RND_W-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem [NUM_ROUNDS];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/sm4_round.sv
// One SM4 round: key XOR, byte substitution, linear mix, fold into X0.
// Depends on sm4_pkg for the S-box.
module sm4_round
  import sm4_pkg::*;
(
  input  logic [31:0] x0_i,
  input  logic [31:0] x1_i,
  input  logic [31:0] x2_i,
  input  logic [31:0] x3_i,
  input  logic [31:0] rk_i,
  output logic [31:0] x_new_o
);

  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] l;

  always_comb begin
    a = x1_i ^ x2_i ^ x3_i ^ rk_i;
    b = {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
    // L(B) = B ^ rotl2 ^ rotl10 ^ rotl18 ^ rotl24
    l = b
      ^ {b[29:0], b[31:30]}
      ^ {b[21:0], b[31:22]}
      ^ {b[13:0], b[31:14]}
      ^ {b[7:0],  b[31:8]};
    x_new_o = x0_i ^ l;
  end

endmodule

### rtl/sm4_block_encrypt.sv
// SM4 block cipher core top level: sequencer, state words and output register.
// Depends on sm4_pkg, sm4_key_ram, sm4_round and assert_macros.svh.
//
//   channel | signals                              | item
//   --------+--------------------------------------+------------------------------
//   in      | in_valid_i, in_ready_o, in_data_i    | key write or 128-bit block
//   out     | out_valid_o, out_ready_i, out_data_o | 128-bit cipher block
//
// A block runs in the round unit at one round per cycle, the key word for each
// round read from the key store one round ahead; the last round waits for the
// output register, which then holds the result. in_ready_o is low while rounds
// run. A result not yet taken holds the last round until the output register
// frees. Reset clears control only; the key store is undefined until written.
`include "assert_macros.svh"

module sm4_block_encrypt
  import sm4_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sm4_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sm4_out_t out_data_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [RND_W-1:0] LastRnd = RND_W'(NUM_ROUNDS - 1);

  state_e           state_q, state_d;
  logic [RND_W-1:0] cnt_q, cnt_d;
  logic [31:0]      x_q [4];
  logic [31:0]      x_d [4];
  logic             out_valid_q, out_valid_d;
  sm4_out_t         out_q, out_d;

  logic             in_acc;
  logic             finish;
  logic             advance;
  sm4_key_wr_t      key_wr;
  logic [RND_W-1:0] rd_addr;
  logic [31:0]      rk;
  logic [31:0]      x_new;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign key_wr.en   = in_acc && (in_data_i.req_type == REQ_KEY);
  assign key_wr.addr = in_data_i.key_index;
  assign key_wr.data = in_data_i.key_word;

  // Last round may complete only once the output register is free.
  assign finish  = (state_q == ST_RUN) && (cnt_q == LastRnd) &&
                   (!out_valid_q || out_ready_i);
  assign advance = (state_q == ST_RUN) && ((cnt_q != LastRnd) || finish);

  // Fetch the key word one round ahead; hold the address while stalled.
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = '0;
    end else if (advance) begin
      rd_addr = cnt_q + RND_W'(1);
    end else begin
      rd_addr = cnt_q;
    end
  end

  sm4_key_ram u_key_ram (
    .clk_i     (clk_i),
    .wr_i      (key_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rk)
  );

  sm4_round u_round (
    .x0_i    (x_q[0]),
    .x1_i    (x_q[1]),
    .x2_i    (x_q[2]),
    .x3_i    (x_q[3]),
    .rk_i    (rk),
    .x_new_o (x_new)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.req_type == REQ_ENC)) begin
          x_d[0]  = in_data_i.block_high[63:32];
          x_d[1]  = in_data_i.block_high[31:0];
          x_d[2]  = in_data_i.block_low[63:32];
          x_d[3]  = in_data_i.block_low[31:0];
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finish) begin
          // Final words leave in reverse order.
          out_d.cipher_high = {x_new, x_q[3]};
          out_d.cipher_low  = {x_q[2], x_q[1]};
          out_valid_d       = 1'b1;
          cnt_d             = '0;
          state_d           = ST_IDLE;
        end else if (advance) begin
          x_d[0] = x_q[1];
          x_d[1] = x_q[2];
          x_d[2] = x_q[3];
          x_d[3] = x_new;
          cnt_d  = cnt_q + RND_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
  end

  `ASSERT_PROP(a_enc_starts_run, clk_i, rst_ni, (in_acc && (in_data_i.req_type == REQ_ENC)) |=> ((state_q == ST_RUN) && (cnt_q == '0)))
  `ASSERT_PROP(a_stall_holds_last, clk_i, rst_ni, ((state_q == ST_RUN) && (cnt_q == LastRnd) && out_valid_q && !out_ready_i) |=> ((state_q == ST_RUN) && (cnt_q == LastRnd) && out_valid_q))
  `ASSERT_NEVER(a_idle_cnt_clear, clk_i, rst_ni, (state_q == ST_IDLE) && (cnt_q != '0))
  `ASSERT_PROP(a_finish_sets_out, clk_i, rst_ni, finish |=> (out_valid_q && (state_q == ST_IDLE)))

endmodule
